### hdl/assert_macros.svh
// Assertion macros for the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/salc_pkg.sv
// Package: constants, register indexes and types of the LRU cache stall counter.
package salc_pkg;

   // Register reset values: one-word bus 8*(1+100+1+2), wide bus 1+100+1+2.
   localparam logic [7:0]  HIT_CYCLES_RST = 8'd4;
   localparam logic [15:0] PEN_A_RST      = 16'(8 * (1 + 100 + 1 + 2));
   localparam logic [15:0] PEN_B_RST      = 16'(1 + 100 + 1 + 2);

   localparam int ADDR_W    = 32;
   localparam int TOTAL_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_HIT_CYCLES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_PEN_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_PEN_B = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } salc_state_type;

   // Elaboration-time floor(log2(v)).
   function automatic int flog2(input int v);
      int n;
      int x;
      n = 0;
      x = v;
      while (x > 1) begin
         x = x >> 1;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

### hdl/salc_ifs.sv
// Interfaces: request, response and register-write channels.
interface salc_req_if import salc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               hit;
   logic [2:0]         way;
   logic               set_index;
   logic [TOTAL_W-1:0] stall_total_a;
   logic [TOTAL_W-1:0] stall_total_b;
   logic [TOTAL_W-1:0] miss_total;

   modport source (output valid, output hit, output way, output set_index,
                   output stall_total_a, output stall_total_b, output miss_total,
                   input ready);
   modport sink   (input valid, input hit, input way, input set_index,
                   input stall_total_a, input stall_total_b, input miss_total,
                   output ready);
endinterface

interface salc_csr_if import salc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/salc_ram.sv
// Generic single-port-write, registered-read RAM.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/salc_way_logic.sv
// Per-set tag match, victim choice and recency-rank update.
module salc_way_logic #(
   parameter int WAYS   = 8,
   parameter int TAG_W  = 26,
   localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1,
   localparam int WAY_W  = RANK_W,
   localparam int ROW_W  = WAYS * (1 + TAG_W + RANK_W)
) (
   input  logic [ROW_W-1:0] row_in,
   input  logic             row_ok,   // row written since reset
   input  logic [TAG_W-1:0] tag,
   output logic             hit,
   output logic [WAY_W-1:0] way,
   output logic [ROW_W-1:0] row_out
);

   localparam int TAG_BASE  = WAYS;
   localparam int RANK_BASE = WAYS + WAYS * TAG_W;

   logic [WAYS-1:0]   vld;
   logic [TAG_W-1:0]  tg [WAYS];
   logic [RANK_W-1:0] rk [WAYS];
   logic [WAYS-1:0]   match;

   always_comb begin
      logic [WAY_W-1:0]  hit_way;
      logic [WAY_W-1:0]  free_way;
      logic [WAY_W-1:0]  lru_way;
      logic [RANK_W:0]   old_rank;
      logic [RANK_W-1:0] new_rk;

      // unwritten row reads as reset: invalid, rank zero
      for (int i = 0; i < WAYS; i++) begin
         vld[i]   = row_ok & row_in[i];
         tg[i]    = row_in[TAG_BASE + i*TAG_W +: TAG_W];
         rk[i]    = row_ok ? row_in[RANK_BASE + i*RANK_W +: RANK_W] : '0;
         match[i] = vld[i] && (tg[i] == tag);
      end

      hit_way  = '0;
      free_way = '0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) hit_way = WAY_W'(i);
         if (!vld[i])  free_way = WAY_W'(i);
      end
      // all ways valid: ranks are a permutation, oldest holds WAYS-1
      lru_way = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (rk[i] == RANK_W'(WAYS - 1)) lru_way = WAY_W'(i);
      end

      hit = |match;
      if (hit) begin
         way = hit_way;
      end else if (!(&vld)) begin
         way = free_way;
      end else begin
         way = lru_way;
      end

      old_rank = vld[way] ? {1'b0, rk[way]} : (RANK_W + 1)'(WAYS);

      row_out = '0;
      for (int i = 0; i < WAYS; i++) begin
         if (WAY_W'(i) == way) begin
            new_rk = '0;
         end else if (vld[i] && ({1'b0, rk[i]} < old_rank)) begin
            new_rk = rk[i] + 1'b1;
         end else begin
            new_rk = rk[i];
         end
         row_out[i] = vld[i] | (WAY_W'(i) == way);
         row_out[TAG_BASE + i*TAG_W +: TAG_W] =
            (!hit && (WAY_W'(i) == way)) ? tag : tg[i];
         row_out[RANK_BASE + i*RANK_W +: RANK_W] = new_rk;
      end
   end

endmodule

### hdl/set_assoc_lru_cache_stall_counter.sv
// Top level: set-associative LRU cache lookup with stall and miss totals.
//
// Usage
//  - req_ch: one byte address per transfer. rsp_ch: one result per request,
//    with hit, way, set and the three running totals after this access.
//  - csr_ch: register writes (0 hit cycles, 1 miss penalty a, 2 miss
//    penalty b); always ready, other indexes ignored. Write only when idle.
//  - Each set lives in one RAM row (valid, tag and rank of every way). A
//    request reads its row on the transfer edge; the lookup state then matches,
//    picks the victim and, once the result register is free, writes the row
//    back and loads the result register.
//  - Each result passes the RAM read register, then the result register.
//  - One request at a time: req_ch.ready is low during the lookup, so a new
//    request waits until the row of the last one has been written back.
//  - A waiting result does not block the next request transfer; the lookup
//    holds only if the result register is still full when it finishes.
//  - Reset (synchronous) clears the row-valid flops, so every set reads as
//    empty with zero ranks; no clearing pass. Totals clear, registers take
//    their defaults (4, 832, 104). Totals saturate at 2^32-1.
//  - SETS and BLOCK_BYTES are powers of two.
`include "assert_macros.svh"

module set_assoc_lru_cache_stall_counter import salc_pkg::*; #(
   parameter int WAYS        = 8,
   parameter int SETS        = 2,
   parameter int BLOCK_BYTES = 32
) (
   input logic          clock,
   input logic          reset,
   salc_req_if.sink     req_ch,
   salc_rsp_if.source   rsp_ch,
   salc_csr_if.sink     csr_ch
);

   localparam int OFF_BITS = flog2(BLOCK_BYTES);
   localparam int IDX_BITS = flog2(SETS);
   localparam int TAG_W    = ADDR_W - OFF_BITS - IDX_BITS;
   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int WAY_W    = RANK_W;
   localparam int ROW_W    = WAYS * (1 + TAG_W + RANK_W);

   // config registers
   logic [7:0]  hit_cycles_ff, hit_cycles_in;
   logic [15:0] pen_a_ff, pen_a_in;
   logic [15:0] pen_b_ff, pen_b_in;

   // control
   salc_state_type    state_ff, state_in;
   logic [SETS-1:0]   row_ok_ff, row_ok_in;
   logic [SET_W-1:0]  set_ff, set_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;

   // totals
   logic [TOTAL_W-1:0] acc_a_ff, acc_a_in;
   logic [TOTAL_W-1:0] acc_b_ff, acc_b_in;
   logic [TOTAL_W-1:0] miss_ff, miss_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [2:0]         rsp_way_ff, rsp_way_in;
   logic               rsp_set_ff, rsp_set_in;

   logic              req_xfer;
   logic              finish;
   logic [SET_W-1:0]  req_set;
   logic [ROW_W-1:0]  row_rd, row_wr;
   logic              lk_hit;
   logic [WAY_W-1:0]  lk_way;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign req_set      = (SETS > 1) ? SET_W'(req_ch.address >> OFF_BITS) : '0;
   // lookup completes once the result register is free
   assign finish       = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ch.ready);

   salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_row_ram (
      .clock (clock),
      .we    (finish),
      .waddr (set_ff),
      .wdata (row_wr),
      .re    (req_xfer),
      .raddr (req_set),
      .rdata (row_rd)
   );

   salc_way_logic #(.WAYS(WAYS), .TAG_W(TAG_W)) u_way_logic (
      .row_in  (row_rd),
      .row_ok  (row_ok_ff[set_ff]),
      .tag     (tag_ff),
      .hit     (lk_hit),
      .way     (lk_way),
      .row_out (row_wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ok_ff     <= '0;
         acc_a_ff      <= '0;
         acc_b_ff      <= '0;
         miss_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         hit_cycles_ff <= HIT_CYCLES_RST;
         pen_a_ff      <= PEN_A_RST;
         pen_b_ff      <= PEN_B_RST;
      end else begin
         state_ff      <= state_in;
         row_ok_ff     <= row_ok_in;
         acc_a_ff      <= acc_a_in;
         acc_b_ff      <= acc_b_in;
         miss_ff       <= miss_in;
         rsp_valid_ff  <= rsp_valid_in;
         hit_cycles_ff <= hit_cycles_in;
         pen_a_ff      <= pen_a_in;
         pen_b_ff      <= pen_b_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      set_ff     <= set_in;
      tag_ff     <= tag_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_way_ff <= rsp_way_in;
      rsp_set_ff <= rsp_set_in;
   end

   // register writes
   always_comb begin
      hit_cycles_in = hit_cycles_ff;
      pen_a_in      = pen_a_ff;
      pen_b_in      = pen_b_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_HIT_CYCLES: hit_cycles_in = csr_ch.data[7:0];
            CSR_MISS_PEN_A: pen_a_in      = csr_ch.data;
            CSR_MISS_PEN_B: pen_b_in      = csr_ch.data;
            default: ;
         endcase
      end
   end

   // sequencer and accounting
   always_comb begin
      logic [TOTAL_W+1:0] sum_a;
      logic [TOTAL_W+1:0] sum_b;

      state_in     = state_ff;
      row_ok_in    = row_ok_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      miss_in      = miss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_way_in   = rsp_way_ff;
      rsp_set_in   = rsp_set_ff;

      // hit time always, penalty on a miss; saturation of the sum equals
      // saturating after each step
      sum_a = {2'b00, acc_a_ff} + (TOTAL_W + 2)'(hit_cycles_ff)
            + (lk_hit ? '0 : (TOTAL_W + 2)'(pen_a_ff));
      sum_b = {2'b00, acc_b_ff} + (TOTAL_W + 2)'(hit_cycles_ff)
            + (lk_hit ? '0 : (TOTAL_W + 2)'(pen_b_ff));

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               set_in   = req_set;
               tag_in   = TAG_W'(req_ch.address >> (OFF_BITS + IDX_BITS));
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (finish) begin
               row_ok_in[set_ff] = 1'b1;
               acc_a_in = (sum_a[TOTAL_W+1:TOTAL_W] != 2'b00) ? '1 : sum_a[TOTAL_W-1:0];
               acc_b_in = (sum_b[TOTAL_W+1:TOTAL_W] != 2'b00) ? '1 : sum_b[TOTAL_W-1:0];
               if (!lk_hit && (miss_ff != '1)) begin
                  miss_in = miss_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_hit_in   = lk_hit;
               rsp_way_in   = 3'(lk_way);
               rsp_set_in   = set_ff[0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.hit           = rsp_hit_ff;
   assign rsp_ch.way           = rsp_way_ff;
   assign rsp_ch.set_index     = rsp_set_ff;
   assign rsp_ch.stall_total_a = acc_a_ff;
   assign rsp_ch.stall_total_b = acc_b_ff;
   assign rsp_ch.miss_total    = miss_ff;

   // a finished lookup never overwrites a result still waiting
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, finish, !rsp_valid_ff || rsp_ch.ready)
   // a request transfer always starts a lookup of its row
   `ASSERT_NEXT(a_accept_lookup, clock, reset, req_xfer, state_ff == ST_LOOKUP)
   // a hit leaves the miss count alone
   `ASSERT_NEXT(a_hit_no_miss, clock, reset, finish && lk_hit, miss_ff == $past(miss_ff))
   // miss count never goes down
   `ASSERT_NEXT(a_miss_monotone, clock, reset, !reset, miss_ff >= $past(miss_ff))

endmodule
